@@ src/drb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the dual budget rate limiter.
// No dependencies; imported by every module of the block.
package drb_pkg;

	localparam int DRB_WORKERS = 8;
	localparam int DRB_VOLUMES = 64;
	localparam logic [47:0] DRB_INITIAL_BUDGET = 48'd1048576;

	localparam int DRB_BUDGET_W = 48;
	localparam int DRB_LIMIT_W  = 47;
	localparam int DRB_FRAC_W   = 20;
	localparam int DRB_BYTES_W  = 32;
	localparam int DRB_SCALE_W  = 11;
	localparam int DRB_MODE_W   = 2;
	localparam int DRB_WORKER_W = 3;
	localparam int DRB_VOLUME_W = 6;

	// request modes; the fourth code behaves as a check
	localparam logic [DRB_MODE_W-1:0] DRB_MODE_CHECK     = 2'd0;
	localparam logic [DRB_MODE_W-1:0] DRB_MODE_REPLENISH = 2'd1;
	localparam logic [DRB_MODE_W-1:0] DRB_MODE_CONSUME   = 2'd2;

	// APB: word index is paddr[DRB_PADDR_W-1:2]
	localparam int DRB_PADDR_W = 3;
	localparam int DRB_DATA_W  = 32;
	localparam logic [DRB_PADDR_W-3:0] DRB_REG_CONSUME_SCALE = 1'b0;
	localparam logic [DRB_SCALE_W-1:0] DRB_SCALE_RESET = 11'd1;

	// stage strobes from the sequencer to the budget arithmetic
	typedef struct packed {
		logic mul_en;
		logic sum_en;
	} drb_ctrl_t;

endpackage

@@ src/drb_budget_ram.sv @@
`timescale 1ns / 1ps
// Budget table: one synchronous RAM holding both budgets of every entry.
// Runs a clearing pass after reset. Depends on drb_pkg.
module drb_budget_ram import drb_pkg::*; #(
	parameter int ENTRIES = DRB_WORKERS * DRB_VOLUMES,
	parameter int IDX_W = 9,
	parameter logic [DRB_BUDGET_W-1:0] INIT = DRB_INITIAL_BUDGET
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [IDX_W-1:0]          rd_idx,
	output logic [2*DRB_BUDGET_W-1:0] rd_data,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_idx,
	input  logic [2*DRB_BUDGET_W-1:0] wr_data,
	output logic                      clr_busy
);

	logic [2*DRB_BUDGET_W-1:0] mem [ENTRIES];
	logic [2*DRB_BUDGET_W-1:0] rd_data_q;
	logic                      clr_busy_q;
	logic [IDX_W-1:0]          clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_idx_q == IDX_W'(ENTRIES - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= {INIT, INIT};
		end else if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign rd_data  = rd_data_q;
	assign clr_busy = clr_busy_q;

endmodule

@@ src/drb_budget_unit.sv @@
`timescale 1ns / 1ps
// Arithmetic for one budget: refill product, consume product, saturating update.
// Two registered stages, then the update logic. Depends on drb_pkg.
module drb_budget_unit import drb_pkg::*; (
	input  logic                           clk,
	input  drb_ctrl_t                      ctrl,
	input  logic [DRB_MODE_W-1:0]          mode,
	input  logic [DRB_LIMIT_W-1:0]         limit,
	input  logic [DRB_FRAC_W-1:0]          fraction,
	input  logic [DRB_BYTES_W-1:0]         cons_a,
	input  logic [DRB_SCALE_W-1:0]         scale,
	input  logic signed [DRB_BUDGET_W-1:0] budget,
	output logic signed [DRB_BUDGET_W-1:0] nxt
);

	localparam int LO_W   = 24;
	localparam int HI_W   = DRB_LIMIT_W - LO_W;
	localparam int PLO_W  = LO_W + DRB_FRAC_W;
	localparam int PHI_W  = HI_W + DRB_FRAC_W;
	localparam int FULL_W = DRB_LIMIT_W + DRB_FRAC_W;
	localparam int Q_W    = FULL_W - 16;
	localparam int CONS_W = DRB_BYTES_W + DRB_SCALE_W;
	localparam int EXT_W  = Q_W + 2;
	localparam logic signed [EXT_W-1:0] B_MAX = EXT_W'(48'h7FFF_FFFF_FFFF);
	localparam logic signed [EXT_W-1:0] B_MIN = ~B_MAX;

	function automatic logic signed [DRB_BUDGET_W-1:0] sat48(input logic signed [EXT_W-1:0] v);
		logic signed [DRB_BUDGET_W-1:0] r;
		if (v > B_MAX) begin
			r = B_MAX[DRB_BUDGET_W-1:0];
		end else if (v < B_MIN) begin
			r = B_MIN[DRB_BUDGET_W-1:0];
		end else begin
			r = v[DRB_BUDGET_W-1:0];
		end
		return r;
	endfunction

	logic [PLO_W-1:0]  plo_s1;
	logic [PHI_W-1:0]  phi_s1;
	logic [CONS_W-1:0] cons_s1;
	logic [FULL_W-1:0] full;
	logic [Q_W-1:0]    q_s2;
	logic              rnz_s2;
	logic [CONS_W-1:0] cons_s2;

	logic signed [EXT_W-1:0] bud_x;
	logic signed [EXT_W-1:0] q_x;
	logic signed [EXT_W-1:0] sum;
	logic signed [EXT_W-1:0] sum_adj;
	logic signed [EXT_W-1:0] rep;
	logic signed [EXT_W-1:0] diff;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			plo_s1  <= PLO_W'(limit[LO_W-1:0]) * PLO_W'(fraction);
			phi_s1  <= PHI_W'(limit[DRB_LIMIT_W-1:LO_W]) * PHI_W'(fraction);
			cons_s1 <= CONS_W'(cons_a) * CONS_W'(scale);
		end
	end

	assign full = {phi_s1, LO_W'(0)} + FULL_W'(plo_s1);

	always_ff @(posedge clk) begin
		if (ctrl.sum_en) begin
			q_s2    <= full[FULL_W-1:16];
			rnz_s2  <= |plo_s1[15:0];
			cons_s2 <= cons_s1;
		end
	end

	always_comb begin
		bud_x = $signed({{(EXT_W-DRB_BUDGET_W){budget[DRB_BUDGET_W-1]}}, budget});
		q_x   = $signed({2'b00, q_s2});
		sum   = bud_x + q_x;
		// negative sum with a fractional remainder truncates one step towards zero
		sum_adj = sum + $signed({{(EXT_W-1){1'b0}}, sum[EXT_W-1] & rnz_s2});
		rep   = (budget > 0) ? q_x : sum_adj;
		diff  = bud_x - $signed({{(EXT_W-CONS_W){1'b0}}, cons_s2});
		case (mode)
			DRB_MODE_REPLENISH: nxt = sat48(rep);
			DRB_MODE_CONSUME:   nxt = sat48(diff);
			default:            nxt = budget;
		endcase
	end

endmodule

@@ src/dual_budget_rate_limiter.sv @@
`timescale 1ns / 1ps
// Top level of the dual budget rate limiter: APB register, sequencer, budget RAM.
// Depends on drb_pkg, drb_budget_ram and drb_budget_unit.
//
// Usage:
//   Request channel (req_valid / req_stall) carries mode, worker, volume, fraction,
//   bw_limit, iops_limit and bytes; a transaction completes when req_valid is high
//   and req_stall low. Each request yields one response transaction on
//   rsp_valid / rsp_stall carrying exceeded.
//   Every in-range request is a read-modify-write of one budget RAM entry: read,
//   multiply, sum, write back, and the response is registered. A new request is
//   taken only once the last has left its update step; the RAM port and the refill
//   multipliers are held by one request at a time. While a response waits under
//   rsp_stall the block still takes one further request and holds it in its final
//   step until the output register frees. After reset the RAM is swept to
//   INITIAL_BUDGET, one entry per cycle, over all WORKERS*VOLUMES entries (512 by
//   default); req_stall stays high meanwhile. consume_scale resets to 1 and is
//   written over APB at byte address 0 by the user, only while idle (unenforced).
//   Requests addressing a worker or volume beyond the table answer exceeded = 1.
module dual_budget_rate_limiter import drb_pkg::*; #(
	parameter int WORKERS = DRB_WORKERS,
	parameter int VOLUMES = DRB_VOLUMES,
	parameter logic [DRB_BUDGET_W-1:0] INITIAL_BUDGET = DRB_INITIAL_BUDGET
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [DRB_PADDR_W-1:0]  paddr,
	input  logic [DRB_DATA_W-1:0]   pwdata,
	output logic [DRB_DATA_W-1:0]   prdata,
	output logic                    pready,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [DRB_MODE_W-1:0]   mode,
	input  logic [DRB_WORKER_W-1:0] worker,
	input  logic [DRB_VOLUME_W-1:0] volume,
	input  logic [DRB_FRAC_W-1:0]   fraction,
	input  logic [DRB_LIMIT_W-1:0]  bw_limit,
	input  logic [DRB_LIMIT_W-1:0]  iops_limit,
	input  logic [DRB_BYTES_W-1:0]  bytes,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic                    exceeded
);

	localparam int ENTRIES = WORKERS * VOLUMES;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_SUM, ST_UPD} state_t;

	state_t                  state_q;
	logic                    rsp_valid_q;
	logic                    exceeded_q;
	logic [DRB_SCALE_W-1:0]  scale_q;

	logic [DRB_MODE_W-1:0]   mode_q;
	logic                    oor_q;
	logic [IDX_W-1:0]        idx_q;
	logic [DRB_FRAC_W-1:0]   fraction_q;
	logic [DRB_LIMIT_W-1:0]  bw_limit_q;
	logic [DRB_LIMIT_W-1:0]  iops_limit_q;
	logic [DRB_BYTES_W-1:0]  bytes_q;

	logic                    clr_busy;
	logic                    accept;
	logic                    oor;
	logic [IDX_W-1:0]        idx;
	logic                    upd_go;
	logic                    mem_we;
	logic                    exc;
	logic                    cfg_wr;
	logic [2*DRB_BUDGET_W-1:0] rd_data;
	logic signed [DRB_BUDGET_W-1:0] bw_cur;
	logic signed [DRB_BUDGET_W-1:0] iops_cur;
	logic signed [DRB_BUDGET_W-1:0] bw_nxt;
	logic signed [DRB_BUDGET_W-1:0] iops_nxt;
	drb_ctrl_t               ctrl;

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[DRB_PADDR_W-1:2] == DRB_REG_CONSUME_SCALE);
	assign prdata = (paddr[DRB_PADDR_W-1:2] == DRB_REG_CONSUME_SCALE)
		? DRB_DATA_W'(scale_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= DRB_SCALE_RESET;
		end else if (cfg_wr) begin
			scale_q <= pwdata[DRB_SCALE_W-1:0];
		end
	end

	// request decode
	assign req_stall = clr_busy || (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign oor       = (32'(worker) >= 32'(WORKERS)) || (32'(volume) >= 32'(VOLUMES));
	assign idx       = IDX_W'(32'(worker) * 32'(VOLUMES) + 32'(volume));

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q       <= mode;
			oor_q        <= oor;
			idx_q        <= idx;
			fraction_q   <= fraction;
			bw_limit_q   <= bw_limit;
			iops_limit_q <= iops_limit;
			bytes_q      <= bytes;
		end
	end

	// sequencer: one entry in flight, so no two accesses to the RAM overlap
	assign upd_go   = (state_q == ST_UPD) && (!rsp_valid_q || !rsp_stall);
	assign mem_we   = upd_go && !oor_q;
	assign ctrl.mul_en = (state_q == ST_MUL);
	assign ctrl.sum_en = (state_q == ST_SUM);
	assign exc = oor_q || (bw_nxt <= 0) || (iops_nxt <= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			exceeded_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_UPD;
				ST_UPD:  if (upd_go) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (upd_go) begin
				rsp_valid_q <= 1'b1;
				exceeded_q  <= exc;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign exceeded  = exceeded_q;

	drb_budget_ram #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W),
		.INIT    (INITIAL_BUDGET)
	) u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept && !oor),
		.rd_idx   (idx),
		.rd_data  (rd_data),
		.wr_en    (mem_we),
		.wr_idx   (idx_q),
		.wr_data  ({bw_nxt, iops_nxt}),
		.clr_busy (clr_busy)
	);

	assign bw_cur   = rd_data[2*DRB_BUDGET_W-1:DRB_BUDGET_W];
	assign iops_cur = rd_data[DRB_BUDGET_W-1:0];

	drb_budget_unit u_bw (
		.clk      (clk),
		.ctrl     (ctrl),
		.mode     (mode_q),
		.limit    (bw_limit_q),
		.fraction (fraction_q),
		.cons_a   (bytes_q),
		.scale    (scale_q),
		.budget   (bw_cur),
		.nxt      (bw_nxt)
	);

	drb_budget_unit u_iops (
		.clk      (clk),
		.ctrl     (ctrl),
		.mode     (mode_q),
		.limit    (iops_limit_q),
		.fraction (fraction_q),
		.cons_a   (DRB_BYTES_W'(1)),
		.scale    (scale_q),
		.budget   (iops_cur),
		.nxt      (iops_nxt)
	);

	// RAM write-back never competes with the clearing pass
	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !clr_busy)
		else $error("budget write during clearing pass");

	// a response only appears out of the final update step
	a_rsp_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_UPD))
		else $error("response raised outside update step");

	// an accepted request always starts the multiply step
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MUL))
		else $error("accepted request did not enter multiply step");

endmodule

@@ sim/dual_budget_rate_limiter_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for dual_budget_rate_limiter: directed and random budget requests,
// consume_scale rewritten between phases. Depends on drb_pkg and the RTL under src/.
module dual_budget_rate_limiter_tb;
	import drb_pkg::*;

	localparam int ENTRY_COUNT = DRB_WORKERS * DRB_VOLUMES;
	localparam logic [DRB_MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam logic [DRB_PADDR_W-1:0] SCALE_ADDR = {DRB_REG_CONSUME_SCALE, 2'b00};
	localparam logic [DRB_PADDR_W-1:0] SPARE_ADDR = {1'b1, 2'b00};

	typedef logic signed [DRB_BUDGET_W-1:0] budget_t;
	typedef logic signed [DRB_BUDGET_W+5:0] wide_t;
	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic [DRB_MODE_W-1:0]   mode;
		logic [DRB_WORKER_W-1:0] worker;
		logic [DRB_VOLUME_W-1:0] volume;
		logic [DRB_FRAC_W-1:0]   fraction;
		logic [DRB_LIMIT_W-1:0]  bw_limit;
		logic [DRB_LIMIT_W-1:0]  iops_limit;
		logic [DRB_BYTES_W-1:0]  bytes;
	} budget_req_t;

	localparam wide_t BUDGET_MAX = 54'sd140737488355327;
	localparam wide_t BUDGET_MIN = -54'sd140737488355328;

	class budget_scoreboard;
		budget_t bw_tab[ENTRY_COUNT];
		budget_t iops_tab[ENTRY_COUNT];
		logic [DRB_SCALE_W-1:0] scale;
		bit exceeded_q[$];
		int errors;
		int results;

		function new();
			foreach (bw_tab[i]) begin
				bw_tab[i] = DRB_INITIAL_BUDGET;
				iops_tab[i] = DRB_INITIAL_BUDGET;
			end
			scale = DRB_SCALE_RESET;
			errors = 0;
			results = 0;
		endfunction

		function int pending();
			return exceeded_q.size();
		endfunction

		function budget_t clamp(wide_t v);
			if (v > BUDGET_MAX)
				return budget_t'(BUDGET_MAX);
			if (v < BUDGET_MIN)
				return budget_t'(BUDGET_MIN);
			return budget_t'(v);
		endfunction

		// refill by limit * fraction (UQ4.16); debt keeps its sign, truncation toward zero
		function budget_t refill(budget_t cur, logic [DRB_LIMIT_W-1:0] lim,
				logic [DRB_FRAC_W-1:0] frac);
			logic [DRB_LIMIT_W+DRB_FRAC_W-1:0] prod;
			wide_t whole;
			wide_t sum;
			prod = (DRB_LIMIT_W+DRB_FRAC_W)'(lim) * (DRB_LIMIT_W+DRB_FRAC_W)'(frac);
			whole = $signed({3'b000, prod[DRB_LIMIT_W+DRB_FRAC_W-1:16]});
			if (cur > 0)
				return clamp(whole);
			sum = wide_t'(cur);
			sum = sum + whole;
			if (sum < 0 && prod[15:0] != '0)
				sum = sum + 1;
			return clamp(sum);
		endfunction

		function void note_request(budget_req_t r);
			int idx;
			wide_t acc;
			logic [DRB_BYTES_W+DRB_SCALE_W-1:0] cost;
			if (r.worker >= DRB_WORKERS || r.volume >= DRB_VOLUMES) begin
				exceeded_q.push_back(1'b1);
				return;
			end
			idx = int'(r.worker) * DRB_VOLUMES + int'(r.volume);
			if (r.mode == DRB_MODE_REPLENISH) begin
				bw_tab[idx] = refill(bw_tab[idx], r.bw_limit, r.fraction);
				iops_tab[idx] = refill(iops_tab[idx], r.iops_limit, r.fraction);
			end else if (r.mode == DRB_MODE_CONSUME) begin
				cost = (DRB_BYTES_W+DRB_SCALE_W)'(r.bytes)
					* (DRB_BYTES_W+DRB_SCALE_W)'(scale);
				acc = wide_t'(bw_tab[idx]);
				bw_tab[idx] = clamp(acc - $signed({11'b0, cost}));
				acc = wide_t'(iops_tab[idx]);
				iops_tab[idx] = clamp(acc - $signed({43'b0, scale}));
			end
			exceeded_q.push_back(bw_tab[idx] <= 0 || iops_tab[idx] <= 0);
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_response(logic got);
			bit want;
			results++;
			if (exceeded_q.size() == 0) begin
				report_mismatch($sformatf("response %0d with no request outstanding", results));
				return;
			end
			want = exceeded_q.pop_front();
			if (got !== want)
				report_mismatch($sformatf("response %0d: exceeded %b, expected %b",
					results, got, want));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [DRB_PADDR_W-1:0] paddr;
	logic [DRB_DATA_W-1:0] pwdata;
	logic [DRB_DATA_W-1:0] prdata;
	logic pready;
	logic req_valid, req_stall;
	logic [DRB_MODE_W-1:0] mode;
	logic [DRB_WORKER_W-1:0] worker;
	logic [DRB_VOLUME_W-1:0] volume;
	logic [DRB_FRAC_W-1:0] fraction;
	logic [DRB_LIMIT_W-1:0] bw_limit, iops_limit;
	logic [DRB_BYTES_W-1:0] bytes;
	logic rsp_valid, rsp_stall;
	logic exceeded;

	budget_scoreboard sb;
	idle_mode_t idle_mode = IDLE_NONE;
	int hold_left = 0;
	logic [DRB_WORKER_W+DRB_VOLUME_W-1:0] hot_entry[6];

	dual_budget_rate_limiter u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_stall(req_stall),
		.mode(mode), .worker(worker), .volume(volume), .fraction(fraction),
		.bw_limit(bw_limit), .iops_limit(iops_limit), .bytes(bytes),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .exceeded(exceeded)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit send_idle();
		case (idle_mode)
			IDLE_SEND: return $urandom_range(99) < 56;
			IDLE_BOTH: return $urandom_range(99) < 17;
			default:   return 1'b0;
		endcase
	endfunction

	function automatic bit recv_idle();
		case (idle_mode)
			IDLE_RECV: return $urandom_range(99) < 56;
			IDLE_BOTH: return $urandom_range(99) < 17;
			default:   return 1'b0;
		endcase
	endfunction

	function automatic budget_req_t make_req(logic [DRB_MODE_W-1:0] m,
			logic [DRB_WORKER_W-1:0] w, logic [DRB_VOLUME_W-1:0] v,
			logic [DRB_FRAC_W-1:0] f, logic [DRB_LIMIT_W-1:0] bwl,
			logic [DRB_LIMIT_W-1:0] iol, logic [DRB_BYTES_W-1:0] b);
		budget_req_t r;
		r.mode = m;
		r.worker = w;
		r.volume = v;
		r.fraction = f;
		r.bw_limit = bwl;
		r.iops_limit = iol;
		r.bytes = b;
		return r;
	endfunction

	function automatic logic [DRB_LIMIT_W-1:0] random_limit();
		int pick;
		pick = $urandom_range(99);
		if (pick < 50)
			return DRB_LIMIT_W'($urandom_range(21'h1FFFFF));
		if (pick < 80)
			return DRB_LIMIT_W'({$urandom, $urandom});
		return DRB_LIMIT_W'($urandom);
	endfunction

	// mostly hammer a few hot entries so debt builds up and recovers
	function automatic budget_req_t random_request();
		budget_req_t r;
		int pick;
		if ($urandom_range(99) < 70)
			{r.worker, r.volume} = hot_entry[$urandom_range(5)];
		else
			{r.worker, r.volume} = (DRB_WORKER_W+DRB_VOLUME_W)'($urandom);
		pick = $urandom_range(99);
		if (pick < 45)
			r.mode = DRB_MODE_CONSUME;
		else if (pick < 75)
			r.mode = DRB_MODE_REPLENISH;
		else if (pick < 95)
			r.mode = DRB_MODE_CHECK;
		else
			r.mode = MODE_SPARE;
		pick = $urandom_range(99);
		if (pick < 40)
			r.fraction = DRB_FRAC_W'($urandom_range(20'h1FFFF));
		else if (pick < 70)
			r.fraction = DRB_FRAC_W'($urandom);
		else
			r.fraction = DRB_FRAC_W'($urandom_range(255));
		r.bw_limit = random_limit();
		r.iops_limit = random_limit();
		pick = $urandom_range(99);
		if (pick < 60)
			r.bytes = DRB_BYTES_W'($urandom_range(4095));
		else if (pick < 85)
			r.bytes = $urandom;
		else if (pick < 93)
			r.bytes = '1;
		else
			r.bytes = '0;
		return r;
	endfunction

	// leaves req_valid high; caller lowers it once the stream ends
	task automatic push_request(budget_req_t r);
		if (send_idle()) begin
			req_valid <= 1'b0;
			@(posedge clk);
			while (send_idle())
				@(posedge clk);
		end
		req_valid <= 1'b1;
		{mode, worker, volume, fraction, bw_limit, iops_limit, bytes} <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(r);
	endtask

	task automatic apb_access(logic wr, logic [DRB_PADDR_W-1:0] addr,
			logic [DRB_DATA_W-1:0] data, output logic [DRB_DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_scale(logic [DRB_SCALE_W-1:0] value);
		logic [DRB_DATA_W-1:0] rdata;
		logic [DRB_DATA_W-1:0] data;
		// junk above the field must be dropped
		data = $urandom;
		data[DRB_SCALE_W-1:0] = value;
		apb_access(1'b1, SCALE_ADDR, data, rdata);
		sb.scale = value;
		apb_access(1'b0, SCALE_ADDR, '0, rdata);
		if (rdata[DRB_SCALE_W-1:0] !== value)
			sb.report_mismatch($sformatf("consume_scale reads %0d, expected %0d",
				rdata[DRB_SCALE_W-1:0], value));
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_phase(logic [DRB_SCALE_W-1:0] scale_val, idle_mode_t idle,
			int count, int hold);
		write_scale(scale_val);
		idle_mode = idle;
		hold_left = hold;
		repeat (count)
			push_request(random_request());
		req_valid <= 1'b0;
		wait_drained();
	endtask

	// response side: check each transaction, then choose the next stall
	initial begin
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				sb.check_response(exceeded);
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= recv_idle();
			end
		end
	end

	initial begin
		#5000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [DRB_DATA_W-1:0] rdata;
		sb = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_valid <= 1'b0;
		{mode, worker, volume, fraction, bw_limit, iops_limit, bytes} <= '0;
		hot_entry[0] = '0;
		hot_entry[1] = '1;
		for (int i = 2; i < 6; i++)
			hot_entry[i] = (DRB_WORKER_W+DRB_VOLUME_W)'($urandom);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset scale, the RAM sweep holds off the first transaction
		push_request(make_req(DRB_MODE_CHECK, 0, 0, 0, 0, 0, 0));
		push_request(make_req(MODE_SPARE, 7, 63, '1, '1, '1, '1));
		push_request(make_req(DRB_MODE_CONSUME, 0, 0, 0, 0, 0, '1));
		// tiny refill on debt: truncation moves the sum toward zero
		push_request(make_req(DRB_MODE_REPLENISH, 0, 0, 1, 1, 1, 0));
		// largest refill saturates high
		push_request(make_req(DRB_MODE_REPLENISH, 0, 0, '1, '1, '1, 0));
		push_request(make_req(DRB_MODE_REPLENISH, 1, 1, 0, '1, '1, 0));
		push_request(make_req(DRB_MODE_REPLENISH, 1, 1, 20'h10000, 5, 3, 0));
		push_request(make_req(DRB_MODE_CONSUME, 1, 1, 0, 0, 0, 5));
		req_valid <= 1'b0;
		wait_drained();

		// largest scale drives one entry into the low saturation bound
		write_scale('1);
		repeat (18)
			push_request(make_req(DRB_MODE_CONSUME, 2, 5, 0, 0, 0, '1));
		push_request(make_req(DRB_MODE_REPLENISH, 2, 5, 20'h08000, 3, 3, 0));
		req_valid <= 1'b0;
		wait_drained();

		// write beyond the register map must leave consume_scale alone
		apb_access(1'b1, SPARE_ADDR, $urandom, rdata);
		apb_access(1'b0, SCALE_ADDR, '0, rdata);
		if (rdata[DRB_SCALE_W-1:0] !== sb.scale)
			sb.report_mismatch("consume_scale changed by write to unused address");

		run_phase('1, IDLE_NONE, 150, 0);
		run_phase('0, IDLE_SEND, 200, 0);
		run_phase(11'd1024, IDLE_RECV, 250, 300);
		run_phase(11'd1, IDLE_BOTH, 250, 0);
		run_phase(DRB_SCALE_W'($urandom_range(2047, 1)), IDLE_NONE, 250, 0);
		run_phase(11'd5, IDLE_SEND, 250, 0);
		run_phase(DRB_SCALE_W'($urandom_range(2047, 1)), IDLE_RECV, 250, 0);
		run_phase(11'd1, IDLE_BOTH, 100, 0);

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
